FILE: rtl/mck_pkg.sv
// shared types and constants of the mecanum chassis kinematics block
package mck_pkg;

  localparam int unsigned DATA_W  = 32;  // field width
  localparam int unsigned MAX_W   = 31;  // wheel speed limit width
  localparam int unsigned FRAC_W  = 16;  // fraction bits of Q16.16
  localparam int unsigned MASK_W  = 4;   // one bit per wheel
  localparam int unsigned N_WHEEL = 4;
  localparam int unsigned N_LANE  = 7;   // four wheel lanes, three estimate lanes
  localparam int unsigned SUMM_W  = 34;  // sum of four measured speeds
  localparam int unsigned PROD_Y_W = 2 * DATA_W;  // yaw times span
  localparam int unsigned MAG_W   = 48;  // magnitude into a lane
  localparam int unsigned WIDE_W  = MAG_W + 1;
  localparam int unsigned PART_W  = MAG_W / 2;
  localparam int unsigned PROD_W  = PART_W + DATA_W;
  localparam int unsigned SUM_W   = MAG_W + DATA_W + 1;
  localparam int unsigned RND_W   = SUM_W - FRAC_W;
  localparam int unsigned IDX_W   = 3;

  // lane slots
  localparam int unsigned LANE_VX  = 4;
  localparam int unsigned LANE_VY  = 5;
  localparam int unsigned LANE_YAW = 6;

  localparam logic [DATA_W-1:0] EST_LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] EST_LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_SPAN_SUM     = 3'd0,
    REG_INVERSE_GAIN = 3'd1,
    REG_MAX_RPM      = 3'd2,
    REG_FORWARD_GAIN = 3'd3,
    REG_YAW_GAIN     = 3'd4,
    REG_PRESENT_MASK = 3'd5
  } mck_reg_t;

  typedef logic signed [DATA_W-1:0] mck_data_t;
  typedef logic signed [SUMM_W-1:0] mck_sum_t;
  typedef logic signed [WIDE_W-1:0] mck_wide_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } mck_front_ld_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } mck_lane_ld_t;

endpackage

FILE: rtl/mck_front.sv
// front pipeline: yaw term, wheel mixing and measured speed sums
module mck_front import mck_pkg::*; (
  input  logic                 clk,
  input  mck_front_ld_t        ld,
  input  mck_data_t            cmd_vx,
  input  mck_data_t            cmd_vy,
  input  mck_data_t            cmd_yaw_rate,
  input  mck_data_t            measured [N_WHEEL],
  input  logic [DATA_W-1:0]    span_sum,
  input  logic [MASK_W-1:0]    present_mask,
  output mck_wide_t            lane_val [N_LANE]
);

  // stage 1
  mck_data_t           vx1_r, vy1_r;
  logic                yaw_neg1_r;
  logic [DATA_W-1:0]   yaw_mag1_r;
  mck_data_t           m1_r [N_WHEEL];
  // stage 2
  mck_data_t           vx2_r, vy2_r;
  logic                yaw_neg2_r;
  logic [PROD_Y_W-1:0] prod2_r;
  mck_sum_t            fx2_r, fy2_r, fw2_r;
  // stage 3
  mck_data_t           vx3_r, vy3_r;
  mck_wide_t           t3_r;
  mck_sum_t            fx3_r, fy3_r, fw3_r;
  // stage 4
  mck_wide_t           lane_val_r [N_LANE];

  logic [DATA_W-1:0]   yaw_neg_val;
  logic [PROD_Y_W-1:0] prod_rnd;
  mck_wide_t           t_mag_w;
  mck_wide_t           vx_w, vy_w;

  assign yaw_neg_val = DATA_W'(0) - cmd_yaw_rate;
  assign prod_rnd    = prod2_r + (PROD_Y_W'(1) << (FRAC_W - 1));
  assign t_mag_w     = mck_wide_t'({1'b0, prod_rnd[PROD_Y_W-2:FRAC_W]});
  assign vx_w        = mck_wide_t'(vx3_r);
  assign vy_w        = mck_wide_t'(vy3_r);

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      vx1_r      <= cmd_vx;
      vy1_r      <= cmd_vy;
      yaw_neg1_r <= cmd_yaw_rate[DATA_W-1];
      yaw_mag1_r <= cmd_yaw_rate[DATA_W-1] ? yaw_neg_val : cmd_yaw_rate;
      for (int i = 0; i < N_WHEEL; i++) begin
        // an absent wheel reads as standing still
        m1_r[i] <= present_mask[i] ? measured[i] : '0;
      end
    end
    if (ld.s2) begin
      vx2_r      <= vx1_r;
      vy2_r      <= vy1_r;
      yaw_neg2_r <= yaw_neg1_r;
      prod2_r    <= yaw_mag1_r * span_sum;
      fx2_r <= mck_sum_t'(m1_r[0]) + mck_sum_t'(m1_r[1])
             + mck_sum_t'(m1_r[2]) + mck_sum_t'(m1_r[3]);
      fy2_r <= mck_sum_t'(m1_r[1]) + mck_sum_t'(m1_r[2])
             - mck_sum_t'(m1_r[0]) - mck_sum_t'(m1_r[3]);
      fw2_r <= mck_sum_t'(m1_r[1]) + mck_sum_t'(m1_r[3])
             - mck_sum_t'(m1_r[0]) - mck_sum_t'(m1_r[2]);
    end
    if (ld.s3) begin
      vx3_r <= vx2_r;
      vy3_r <= vy2_r;
      // round half away from zero on the magnitude, then restore sign
      t3_r  <= yaw_neg2_r ? -t_mag_w : t_mag_w;
      fx3_r <= fx2_r;
      fy3_r <= fy2_r;
      fw3_r <= fw2_r;
    end
    if (ld.s4) begin
      lane_val_r[0]        <= vx_w - vy_w - t3_r;
      lane_val_r[1]        <= vx_w + vy_w + t3_r;
      lane_val_r[2]        <= vx_w + vy_w - t3_r;
      lane_val_r[3]        <= vx_w - vy_w + t3_r;
      lane_val_r[LANE_VX]  <= mck_wide_t'(fx3_r);
      lane_val_r[LANE_VY]  <= mck_wide_t'(fy3_r);
      lane_val_r[LANE_YAW] <= mck_wide_t'(fw3_r);
    end
  end

  assign lane_val = lane_val_r;

endmodule

FILE: rtl/mck_lane.sv
// one scaling lane: magnitude, split multiply, rounding and clamp
module mck_lane import mck_pkg::*; (
  input  logic              clk,
  input  mck_lane_ld_t      ld,
  input  mck_wide_t         val,
  input  logic [DATA_W-1:0] gain,
  input  logic [DATA_W-1:0] lim_pos,
  input  logic [DATA_W-1:0] lim_neg,
  output logic              res_sign,
  output logic [DATA_W-1:0] res_mag
);

  logic              sign_a_r, sign_b_r, sign_c_r, sign_d_r;
  logic [MAG_W-1:0]  mag_a_r;
  logic [PROD_W-1:0] pp_lo_r, pp_hi_r;
  logic [RND_W-1:0]  rnd_r;
  logic [DATA_W-1:0] mag_d_r;

  mck_wide_t         neg_val;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] lim;

  assign neg_val = -val;
  assign sum = (SUM_W'(pp_hi_r) << PART_W) + SUM_W'(pp_lo_r)
             + (SUM_W'(1) << (FRAC_W - 1));
  assign lim = sign_c_r ? lim_neg : lim_pos;

  always_ff @(posedge clk) begin
    if (ld.a) begin
      sign_a_r <= val[WIDE_W-1];
      mag_a_r  <= val[WIDE_W-1] ? neg_val[MAG_W-1:0] : val[MAG_W-1:0];
    end
    if (ld.b) begin
      sign_b_r <= sign_a_r;
      pp_lo_r  <= mag_a_r[PART_W-1:0] * gain;
      pp_hi_r  <= mag_a_r[MAG_W-1:PART_W] * gain;
    end
    if (ld.c) begin
      sign_c_r <= sign_b_r;
      rnd_r    <= sum[SUM_W-1:FRAC_W];
    end
    if (ld.d) begin
      sign_d_r <= sign_c_r;
      mag_d_r  <= (rnd_r > RND_W'(lim)) ? lim : rnd_r[DATA_W-1:0];
    end
  end

  assign res_sign = sign_d_r;
  assign res_mag  = mag_d_r;

endmodule

FILE: rtl/mck_merge.sv
// output stage: restores signs, drops absent wheels and holds the result word
module mck_merge import mck_pkg::*; (
  input  logic              clk,
  input  logic              ld,
  input  logic              res_sign [N_LANE],
  input  logic [DATA_W-1:0] res_mag [N_LANE],
  input  logic [MASK_W-1:0] present_mask,
  output mck_data_t         target_rpm [N_WHEEL],
  output logic [MASK_W-1:0] targets_valid,
  output mck_data_t         est_vx,
  output mck_data_t         est_vy,
  output mck_data_t         est_yaw_rate
);

  mck_data_t         val [N_LANE];
  mck_data_t         target_r [N_WHEEL];
  logic [MASK_W-1:0] valid_r;
  mck_data_t         est_vx_r, est_vy_r, est_yaw_r;

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      val[i] = res_sign[i] ? mck_data_t'(DATA_W'(0) - res_mag[i]) : mck_data_t'(res_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int i = 0; i < N_WHEEL; i++) begin
        target_r[i] <= present_mask[i] ? val[i] : '0;
      end
      valid_r   <= present_mask;
      est_vx_r  <= val[LANE_VX];
      est_vy_r  <= val[LANE_VY];
      est_yaw_r <= val[LANE_YAW];
    end
  end

  assign target_rpm    = target_r;
  assign targets_valid = valid_r;
  assign est_vx        = est_vx_r;
  assign est_vy        = est_vy_r;
  assign est_yaw_rate  = est_yaw_r;

endmodule

FILE: rtl/mecanum_chassis_kinematics.sv
// top level of the mecanum chassis kinematics block
//
//   port group  direction  handshake            payload
//   in_*        input      in_valid / in_stall   twist command, four measured wheel speeds
//   out_*       output     out_valid / out_stall four wheel targets, valid flags, twist estimate
//   cfg_*       input      cfg_wr_en             register index and write data
//
// one word per cycle sustained while out_stall is low; a word passes through 4 front stages,
// 4 lane stages set by the two 24x32 partial products per lane, and 1 output register.
// rst_n is synchronous: clears stage valid bits and loads the register reset values.
// out_stall backs up through the stage valid bits; in_stall rises only when every
// stage holds a word and the output is stalled.
module mecanum_chassis_kinematics import mck_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_cmd_vx,
  input  logic signed [DATA_W-1:0] in_cmd_vy,
  input  logic signed [DATA_W-1:0] in_cmd_yaw_rate,
  input  logic signed [DATA_W-1:0] in_measured_rpm_0,
  input  logic signed [DATA_W-1:0] in_measured_rpm_1,
  input  logic signed [DATA_W-1:0] in_measured_rpm_2,
  input  logic signed [DATA_W-1:0] in_measured_rpm_3,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_target_rpm_0,
  output logic signed [DATA_W-1:0] out_target_rpm_1,
  output logic signed [DATA_W-1:0] out_target_rpm_2,
  output logic signed [DATA_W-1:0] out_target_rpm_3,
  output logic [MASK_W-1:0]        out_targets_valid,
  output logic signed [DATA_W-1:0] out_est_vx,
  output logic signed [DATA_W-1:0] out_est_vy,
  output logic signed [DATA_W-1:0] out_est_yaw_rate,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned N_STG   = 9;
  localparam int unsigned STG_OUT = N_STG - 1;

  logic [DATA_W-1:0] span_r, inv_gain_r, fwd_gain_r, yaw_gain_r;
  logic [MAX_W-1:0]  max_rpm_r;
  logic [MASK_W-1:0] mask_r;

  logic [N_STG-1:0] v_r, v_nxt, rdy;

  mck_front_ld_t     front_ld;
  mck_lane_ld_t      lane_ld;
  mck_data_t         measured [N_WHEEL];
  mck_wide_t         lane_val [N_LANE];
  logic              res_sign [N_LANE];
  logic [DATA_W-1:0] res_mag [N_LANE];
  logic [DATA_W-1:0] lane_gain [N_LANE];
  logic [DATA_W-1:0] lane_lim_pos [N_LANE];
  logic [DATA_W-1:0] lane_lim_neg [N_LANE];
  mck_data_t         target_rpm [N_WHEEL];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r     <= DATA_W'(65536);
      inv_gain_r <= DATA_W'(65536);
      max_rpm_r  <= '1;
      fwd_gain_r <= DATA_W'(65536);
      yaw_gain_r <= DATA_W'(65536);
      mask_r     <= '1;
    end else if (cfg_wr_en) begin
      case (mck_reg_t'(cfg_index))
        REG_SPAN_SUM:     span_r     <= cfg_wdata;
        REG_INVERSE_GAIN: inv_gain_r <= cfg_wdata;
        REG_MAX_RPM:      max_rpm_r  <= cfg_wdata[MAX_W-1:0];
        REG_FORWARD_GAIN: fwd_gain_r <= cfg_wdata;
        REG_YAW_GAIN:     yaw_gain_r <= cfg_wdata;
        REG_PRESENT_MASK: mask_r     <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid chain; a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[STG_OUT] = !v_r[STG_OUT] || !out_stall;
    for (int k = STG_OUT - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < N_STG; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[STG_OUT];

  assign front_ld = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3]};
  assign lane_ld  = '{a: rdy[4], b: rdy[5], c: rdy[6], d: rdy[7]};

  assign measured[0] = in_measured_rpm_0;
  assign measured[1] = in_measured_rpm_1;
  assign measured[2] = in_measured_rpm_2;
  assign measured[3] = in_measured_rpm_3;

  mck_front u_front (
    .clk          (clk),
    .ld           (front_ld),
    .cmd_vx       (in_cmd_vx),
    .cmd_vy       (in_cmd_vy),
    .cmd_yaw_rate (in_cmd_yaw_rate),
    .measured     (measured),
    .span_sum     (span_r),
    .present_mask (mask_r),
    .lane_val     (lane_val)
  );

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      if (i < N_WHEEL) begin
        lane_gain[i]    = inv_gain_r;
        lane_lim_pos[i] = {1'b0, max_rpm_r};
        lane_lim_neg[i] = {1'b0, max_rpm_r};
      end else begin
        lane_gain[i]    = (i == LANE_YAW) ? yaw_gain_r : fwd_gain_r;
        lane_lim_pos[i] = EST_LIM_POS;
        lane_lim_neg[i] = EST_LIM_NEG;
      end
    end
  end

  for (genvar g = 0; g < N_LANE; g++) begin : g_lane
    mck_lane u_lane (
      .clk      (clk),
      .ld       (lane_ld),
      .val      (lane_val[g]),
      .gain     (lane_gain[g]),
      .lim_pos  (lane_lim_pos[g]),
      .lim_neg  (lane_lim_neg[g]),
      .res_sign (res_sign[g]),
      .res_mag  (res_mag[g])
    );
  end

  mck_merge u_merge (
    .clk           (clk),
    .ld            (rdy[STG_OUT]),
    .res_sign      (res_sign),
    .res_mag       (res_mag),
    .present_mask  (mask_r),
    .target_rpm    (target_rpm),
    .targets_valid (out_targets_valid),
    .est_vx        (out_est_vx),
    .est_vy        (out_est_vy),
    .est_yaw_rate  (out_est_yaw_rate)
  );

  assign out_target_rpm_0 = target_rpm[0];
  assign out_target_rpm_1 = target_rpm[1];
  assign out_target_rpm_2 = target_rpm[2];
  assign out_target_rpm_3 = target_rpm[3];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word lost at first stage");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && out_stall |-> in_stall)
    else $error("input taken while pipeline full and stalled");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_targets_valid[0] |-> out_target_rpm_0 == '0)
    else $error("absent wheel has nonzero target");

  a_target_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_rpm_1 <= $signed({1'b0, max_rpm_r}))
               && (out_target_rpm_1 >= -$signed({1'b0, max_rpm_r})))
    else $error("wheel target beyond limit");

endmodule

FILE: dv/mck_kin_checker.sv
// checker for the mecanum kinematics block: predicts each result word and compares it
module mck_kin_checker import mck_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_cmd_vx,
  input  logic signed [DATA_W-1:0] in_cmd_vy,
  input  logic signed [DATA_W-1:0] in_cmd_yaw_rate,
  input  logic signed [DATA_W-1:0] in_measured_rpm_0,
  input  logic signed [DATA_W-1:0] in_measured_rpm_1,
  input  logic signed [DATA_W-1:0] in_measured_rpm_2,
  input  logic signed [DATA_W-1:0] in_measured_rpm_3,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_target_rpm_0,
  input  logic signed [DATA_W-1:0] out_target_rpm_1,
  input  logic signed [DATA_W-1:0] out_target_rpm_2,
  input  logic signed [DATA_W-1:0] out_target_rpm_3,
  input  logic [MASK_W-1:0]        out_targets_valid,
  input  logic signed [DATA_W-1:0] out_est_vx,
  input  logic signed [DATA_W-1:0] out_est_vy,
  input  logic signed [DATA_W-1:0] out_est_yaw_rate,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output int                       fail_count,
  output int                       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] acc_t;

  typedef struct packed {
    logic [N_WHEEL-1:0][DATA_W-1:0] target;
    logic [MASK_W-1:0]              present;
    logic [DATA_W-1:0]              vx;
    logic [DATA_W-1:0]              vy;
    logic [DATA_W-1:0]              yaw;
  } drive_word_t;

  localparam logic [63:0] SPIN_CAP  = 64'h2000_0000_0000_0000;
  localparam logic [63:0] FIELD_CAP = 64'h0000_0001_0000_0000;
  localparam acc_t        EST_MAX   = 64'sd2147483647;
  localparam acc_t        EST_MIN   = -64'sd2147483648;

  logic [DATA_W-1:0] span_sum;
  logic [DATA_W-1:0] inverse_gain;
  logic [MAX_W-1:0]  rpm_limit;
  logic [DATA_W-1:0] forward_gain;
  logic [DATA_W-1:0] yaw_gain;
  logic [MASK_W-1:0] present_mask;

  drive_word_t drive_q[$];

  // round(x * g / 2^16), to nearest with ties away from zero, magnitude capped
  function automatic acc_t q16_scale(acc_t x, logic [DATA_W-1:0] g, logic [63:0] cap);
    logic [63:0]  m;
    logic [127:0] p;
    m = (x < 0) ? -x : x;
    p = (128'(m) * 128'(g) + 128'h8000) >> FRAC_W;
    if (p > 128'(cap)) p = 128'(cap);
    return (x < 0) ? -acc_t'(p[63:0]) : acc_t'(p[63:0]);
  endfunction

  function automatic logic [DATA_W-1:0] sat_field(acc_t x);
    if (x > EST_MAX) return EST_LIM_POS;
    if (x < EST_MIN) return EST_LIM_NEG;
    return x[DATA_W-1:0];
  endfunction

  function automatic drive_word_t mecanum_solve(logic signed [DATA_W-1:0] vx,
                                                logic signed [DATA_W-1:0] vy,
                                                logic signed [DATA_W-1:0] yaw,
                                                logic [N_WHEEL-1:0][DATA_W-1:0] meas);
    acc_t        spin;
    acc_t        lim;
    acc_t        s;
    acc_t        w [N_WHEEL];
    acc_t        m [N_WHEEL];
    drive_word_t d;
    int          i;
    spin = q16_scale(acc_t'(yaw), span_sum, SPIN_CAP);
    // mecanum roller signs per wheel
    w[0] = acc_t'(vx) - acc_t'(vy) - spin;
    w[1] = acc_t'(vx) + acc_t'(vy) + spin;
    w[2] = acc_t'(vx) + acc_t'(vy) - spin;
    w[3] = acc_t'(vx) - acc_t'(vy) + spin;
    lim = acc_t'(rpm_limit);
    for (i = 0; i < N_WHEEL; i++) begin
      s = q16_scale(w[i], inverse_gain, FIELD_CAP);
      if (s > lim) s = lim;
      else if (s < -lim) s = -lim;
      d.target[i] = present_mask[i] ? s[DATA_W-1:0] : '0;
      m[i] = present_mask[i] ? acc_t'($signed(meas[i])) : '0;
    end
    d.present = present_mask;
    d.vx  = sat_field(q16_scale(m[0] + m[1] + m[2] + m[3], forward_gain, FIELD_CAP));
    d.vy  = sat_field(q16_scale(-m[0] + m[1] + m[2] - m[3], forward_gain, FIELD_CAP));
    d.yaw = sat_field(q16_scale(-m[0] + m[1] - m[2] + m[3], yaw_gain, FIELD_CAP));
    return d;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    drive_word_t got;
    int          i;
    if (!rst_n) begin
      span_sum      <= 32'h0001_0000;
      inverse_gain  <= 32'h0001_0000;
      rpm_limit     <= {MAX_W{1'b1}};
      forward_gain  <= 32'h0001_0000;
      yaw_gain      <= 32'h0001_0000;
      present_mask  <= {MASK_W{1'b1}};
      drive_q.delete();
      fail_count    = 0;
      pending_words <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.target  = {out_target_rpm_3, out_target_rpm_2, out_target_rpm_1, out_target_rpm_0};
        got.present = out_targets_valid;
        got.vx      = out_est_vx;
        got.vy      = out_est_vy;
        got.yaw     = out_est_yaw_rate;
        if (drive_q.size() == 0) begin
          $display("%0t: result word expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          for (i = 0; i < N_WHEEL; i++)
            compare_field($sformatf("target_rpm_%0d", i), want.target[i], got.target[i]);
          compare_field("targets_valid", DATA_W'(want.present), DATA_W'(got.present));
          compare_field("est_vx", want.vx, got.vx);
          compare_field("est_vy", want.vy, got.vy);
          compare_field("est_yaw_rate", want.yaw, got.yaw);
        end
      end
      // prediction uses the settings in force before any write at this edge
      if (in_valid && !in_stall)
        drive_q.push_back(mecanum_solve(in_cmd_vx, in_cmd_vy, in_cmd_yaw_rate,
                                        {in_measured_rpm_3, in_measured_rpm_2,
                                         in_measured_rpm_1, in_measured_rpm_0}));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SPAN_SUM:     span_sum     <= cfg_wdata;
          REG_INVERSE_GAIN: inverse_gain <= cfg_wdata;
          REG_MAX_RPM:      rpm_limit    <= cfg_wdata[MAX_W-1:0];
          REG_FORWARD_GAIN: forward_gain <= cfg_wdata;
          REG_YAW_GAIN:     yaw_gain     <= cfg_wdata;
          REG_PRESENT_MASK: present_mask <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      pending_words <= drive_q.size();
    end
  end

endmodule

FILE: dv/mecanum_chassis_kinematics_tb.sv
// testbench top: drives twist commands, wheel speeds, register writes and output stalls, gives the verdict
module mecanum_chassis_kinematics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mck_pkg::*;

  localparam int unsigned N_RANDOM    = 2000;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 12;  // a little over the pipeline depth

  // indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [DATA_W-1:0] F_MAX = EST_LIM_POS;
  localparam logic [DATA_W-1:0] F_MIN = EST_LIM_NEG;
  localparam logic [DATA_W-1:0] ONE   = 32'h0001_0000;
  localparam logic [DATA_W-1:0] HALF  = 32'h0000_8000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_cmd_vx = '0;
  logic signed [DATA_W-1:0] in_cmd_vy = '0;
  logic signed [DATA_W-1:0] in_cmd_yaw_rate = '0;
  logic signed [DATA_W-1:0] in_measured_rpm_0 = '0;
  logic signed [DATA_W-1:0] in_measured_rpm_1 = '0;
  logic signed [DATA_W-1:0] in_measured_rpm_2 = '0;
  logic signed [DATA_W-1:0] in_measured_rpm_3 = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_target_rpm_0;
  logic signed [DATA_W-1:0] out_target_rpm_1;
  logic signed [DATA_W-1:0] out_target_rpm_2;
  logic signed [DATA_W-1:0] out_target_rpm_3;
  logic [MASK_W-1:0]        out_targets_valid;
  logic signed [DATA_W-1:0] out_est_vx;
  logic signed [DATA_W-1:0] out_est_vy;
  logic signed [DATA_W-1:0] out_est_yaw_rate;
  logic                     cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  int                       fail_count;
  int                       pending_words;
  int unsigned              cycles = 0;
  bit                       calm_tx = 1'b0;

  mecanum_chassis_kinematics dut (.*);
  mck_kin_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mecanum_chassis_kinematics_tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_field();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return F_MIN;
          1: return F_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      // within +/-16.0
      1, 2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ONE;
      3, 4, 5: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 32'h0100_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_mask();
    return ($urandom_range(0, 1) == 0) ? 32'h0000_000f : $urandom();
  endfunction

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // every register, plus a stray write to an index that must be ignored
  task automatic load_config(input logic [DATA_W-1:0] span, input logic [DATA_W-1:0] inv,
                             input logic [DATA_W-1:0] lim, input logic [DATA_W-1:0] fwd,
                             input logic [DATA_W-1:0] yawg, input logic [DATA_W-1:0] mask);
    reg_write(REG_SPAN_SUM, span);
    reg_write(REG_INVERSE_GAIN, inv);
    reg_write(REG_MAX_RPM, lim);
    reg_write(REG_FORWARD_GAIN, fwd);
    reg_write(REG_YAW_GAIN, yawg);
    reg_write(REG_PRESENT_MASK, mask);
    reg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    cfg_wr_en <= 1'b0;
  endtask

  // valid stays high across back-to-back words, it only drops on a gap or in wait_idle
  task automatic send_word(input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                           input logic [DATA_W-1:0] yaw, input logic [DATA_W-1:0] m0,
                           input logic [DATA_W-1:0] m1, input logic [DATA_W-1:0] m2,
                           input logic [DATA_W-1:0] m3);
    int unsigned gap;
    gap = calm_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd_vx         <= vx;
    in_cmd_vy         <= vy;
    in_cmd_yaw_rate   <= yaw;
    in_measured_rpm_0 <= m0;
    in_measured_rpm_1 <= m1;
    in_measured_rpm_2 <= m2;
    in_measured_rpm_3 <= m3;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 24) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings out of reset: unit gains, widest limit, all wheels present
    send_word('0, '0, '0, '0, '0, '0, '0);
    send_word(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
    send_word(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
    send_word(F_MAX, F_MIN, F_MAX, F_MAX, F_MIN, F_MAX, F_MIN);
    send_word(32'h0002_0000, -ONE, HALF, 32'h0064_0000, 32'hffce_0000, 32'h0019_0000,
              32'hfff3_8000);
    send_word('1, '1, '1, '1, '1, '1, '1);
    wait_idle();

    // half gains put rounding on exact ties; wheels 1 and 3 absent
    load_config(HALF, HALF, 32'h0001_8000, HALF, HALF, 32'h0000_0005);
    send_word(32'd1, '0, '0, 32'd1, 32'd1, 32'd1, 32'd1);
    send_word('1, '0, '1, '1, '1, '1, '1);
    send_word(32'd3, 32'd1, 32'd1, 32'd3, -32'd3, 32'd5, -32'd5);
    send_word(32'h0004_0000, '0, '0, F_MAX, '0, F_MAX, '0);
    send_word(32'hfffc_0000, '0, '0, F_MIN, F_MIN, F_MIN, F_MIN);
    send_word(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
    wait_idle();

    // largest gains and spans: products far past every field
    load_config('1, '1, '1, '1, '1, '1);
    send_word(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
    send_word(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
    send_word(32'd1, 32'd2, 32'd3, 32'd4, -32'd5, 32'd6, -32'd7);
    send_word(rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field());
    wait_idle();

    // zero gains, zero limit, no wheels
    load_config('0, '0, '0, '0, '0, '0);
    send_word(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
    send_word(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
    send_word(F_MAX, F_MIN, ONE, ONE, F_MIN, F_MAX, '1);
    wait_idle();

    for (p = 0; p < N_PHASES; p++) begin
      load_config(rand_gain(), rand_gain(), rand_limit(), rand_gain(), rand_gain(),
                  rand_mask());
      for (k = 0; k < N_RANDOM / N_PHASES; k++) begin
        if (k % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
        send_word(rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
                  rand_field(), rand_field());
      end
      calm_tx = 1'b0;
      wait_idle();
    end

    if (fail_count == 0)
      $display("mecanum_chassis_kinematics_tb: PASS");
    else
      $display("mecanum_chassis_kinematics_tb: FAIL");
    $finish;
  end

endmodule
